// ----- design/tcp_rrt_pkg.sv -----
// Shared types and constants for the TCP receive reassembly tracker.
`default_nettype none

package tcp_rrt_pkg;

   // Bitmap row geometry: one memory word holds the flags of 64 bytes.
   localparam int ROW_W     = 64;
   localparam int ROW_SHIFT = 6;

   // Configuration register map (word index = paddr[3:2]).
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_INITIAL_SEQ = 2'd0;
   localparam logic [1:0] REG_WINDOW_SIZE = 2'd1;
   localparam logic [1:0] REG_MAX_SEGMENT = 2'd2;

   localparam logic [31:0] INITIAL_SEQ_RESET = 32'd0;
   localparam logic [15:0] WINDOW_SIZE_RESET = 16'd65535;
   localparam logic [15:0] MAX_SEGMENT_RESET = 16'd1460;

   // Finish status codes.
   localparam logic [1:0] FIN_NONE      = 2'd0;
   localparam logic [1:0] FIN_WITH_DATA = 2'd1;
   localparam logic [1:0] FIN_NO_DATA   = 2'd2;

   typedef struct packed {
      logic [31:0] seq_number;
      logic [15:0] data_length;
      logic        fin_flag;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] ack_offset;
      logic        send_ack;
      logic        length_error;
      logic        in_window;
      logic        below_max;
      logic [31:0] data_segments;
      logic [15:0] largest_length;
      logic [1:0]  finish_status;
   } rsp_payload_type;

   // Command from the segment logic to the bitmap engine.
   typedef struct packed {
      logic start;
      logic mark;
   } map_ctl_type;

   // Status of the bitmap engine.
   typedef struct packed {
      logic ready;
      logic done;
   } map_sts_type;

endpackage

`default_nettype wire

// ----- design/tcp_rrt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcp_rrt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/tcp_rrt_map.sv -----
// Received-byte bitmap engine: clearing pass, range marking and in-order advance.
`default_nettype none

module tcp_rrt_map
   import tcp_rrt_pkg::*;
#(
   parameter int MAP_BYTES = 16384
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire map_ctl_type                      ctl,
   input  wire logic [$clog2(MAP_BYTES+1)-1:0]   lo,
   input  wire logic [$clog2(MAP_BYTES+1)-1:0]   hi,
   output      map_sts_type                      sts,
   output      logic [$clog2(MAP_BYTES+1)-1:0]   next_exp
);

   localparam int OFF_W = $clog2(MAP_BYTES + 1);
   localparam int ROWS  = (MAP_BYTES + ROW_W - 1) / ROW_W;
   localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [2:0] {
      M_CLEAR,
      M_IDLE,
      M_MARK_RD,
      M_MARK_WR,
      M_ADV_RD,
      M_ADV_CHK
   } map_state_type;

   map_state_type          state_ff;
   logic [RA_W-1:0]        row_ff;
   logic [RA_W-1:0]        lo_row_ff;
   logic [RA_W-1:0]        last_row_ff;
   logic [ROW_SHIFT-1:0]   lo_bit_ff;
   logic [ROW_SHIFT:0]     hi_bit_ff;
   logic [OFF_W-1:0]       next_exp_ff;
   logic                   done_ff;

   logic                   ram_wr_en;
   logic [RA_W-1:0]        ram_wr_addr;
   logic [ROW_W-1:0]       ram_wr_data;
   logic                   ram_rd_en;
   logic [RA_W-1:0]        ram_rd_addr;
   logic [ROW_W-1:0]       ram_rd_data;

   logic [OFF_W-1:0]       hi_last;
   logic [ROW_SHIFT-1:0]   mask_lo;
   logic [ROW_SHIFT:0]     mask_hi;
   logic [ROW_W-1:0]       mask;
   logic [ROW_W-1:0]       run_word;
   logic [ROW_SHIFT:0]     run_len;
   logic [OFF_W-1:0]       next_exp_adv;
   logic                   exp_in_map;

   assign hi_last    = hi - OFF_W'(1);
   assign exp_in_map = next_exp_ff < OFF_W'(MAP_BYTES);

   // Bits of the current row that fall inside [lo, hi).
   always_comb begin
      mask_lo = (row_ff == lo_row_ff) ? lo_bit_ff : '0;
      mask_hi = (row_ff == last_row_ff) ? hi_bit_ff : (ROW_SHIFT+1)'(ROW_W);
      for (int j = 0; j < ROW_W; j++) begin
         mask[j] = ((ROW_SHIFT+1)'(j) >= {1'b0, mask_lo}) && ((ROW_SHIFT+1)'(j) < mask_hi);
      end
   end

   // Length of the run of received bytes starting at next_exp within its row.
   always_comb begin
      run_word = ram_rd_data >> next_exp_ff[ROW_SHIFT-1:0];
      run_len  = (ROW_SHIFT+1)'(ROW_W);
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (!run_word[i]) begin
            run_len = (ROW_SHIFT+1)'(i);
         end
      end
   end

   assign next_exp_adv = next_exp_ff + OFF_W'(run_len);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = row_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = row_ff;
      unique case (state_ff)
         M_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         M_MARK_RD: begin
            ram_rd_en = 1'b1;
         end
         M_MARK_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data | mask;
         end
         M_ADV_RD: begin
            ram_rd_en   = exp_in_map;
            ram_rd_addr = RA_W'(next_exp_ff >> ROW_SHIFT);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= M_CLEAR;
         row_ff      <= '0;
         next_exp_ff <= OFF_W'(1);
         done_ff     <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_CLEAR: begin
               if (row_ff == RA_W'(ROWS - 1)) begin
                  state_ff <= M_IDLE;
               end else begin
                  row_ff <= row_ff + RA_W'(1);
               end
            end
            M_IDLE: begin
               if (ctl.start) begin
                  row_ff      <= RA_W'(lo >> ROW_SHIFT);
                  lo_row_ff   <= RA_W'(lo >> ROW_SHIFT);
                  last_row_ff <= RA_W'(hi_last >> ROW_SHIFT);
                  lo_bit_ff   <= lo[ROW_SHIFT-1:0];
                  hi_bit_ff   <= {1'b0, hi_last[ROW_SHIFT-1:0]} + (ROW_SHIFT+1)'(1);
                  state_ff    <= ctl.mark ? M_MARK_RD : M_ADV_RD;
               end
            end
            M_MARK_RD: begin
               state_ff <= M_MARK_WR;
            end
            M_MARK_WR: begin
               if (row_ff == last_row_ff) begin
                  state_ff <= M_ADV_RD;
               end else begin
                  row_ff   <= row_ff + RA_W'(1);
                  state_ff <= M_MARK_RD;
               end
            end
            M_ADV_RD: begin
               if (exp_in_map) begin
                  state_ff <= M_ADV_CHK;
               end else begin
                  done_ff  <= 1'b1;
                  state_ff <= M_IDLE;
               end
            end
            M_ADV_CHK: begin
               next_exp_ff <= next_exp_adv;
               // keep scanning only when the run reached the end of the row
               if (run_len != '0 && next_exp_adv[ROW_SHIFT-1:0] == '0) begin
                  state_ff <= M_ADV_RD;
               end else begin
                  done_ff  <= 1'b1;
                  state_ff <= M_IDLE;
               end
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign sts.ready = (state_ff == M_IDLE);
   assign sts.done  = done_ff;
   assign next_exp  = next_exp_ff;

   tcp_rrt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ----- design/tcp_receive_reassembly_tracker.sv -----
// TCP receive reassembly tracker top level: segment checks, counters, CSRs, result register.
//
// Usage: each transaction on the req_ channel is one received segment (sequence
// number, data length, FIN). Each accepted segment yields exactly one transaction
// on the rsp_ channel with the next expected offset, the segment flags and the
// running counters. initial_seq, window_size and max_segment are written over the
// csr_ port (byte addresses 0, 4, 8) while no segment is in flight.
// Timing: one segment is processed at a time. After acceptance an oversized segment
// goes from the length check straight to the result, and one outside the window goes there
// after the window test. Otherwise the bitmap engine reads and then writes each 64-byte row
// that the segment marks, and reads and checks each row that the in-order scan covers (with
// one more step when the scan reaches the end of the bitmap). The next segment can be taken
// in the cycle after the result is loaded. An in-order 1460-byte segment marks 23 or 24 rows
// and scans 23 to 25. Rows pass through the bitmap memory's single read and single write port.
// Reset: synchronous; afterwards the bitmap memory is cleared one row per cycle,
// MAP_BYTES/64 rows (256 at the default size), with req_stall held high.
// CSR writes are taken during that pass. The next expected offset resets to one.
// Output: the result sits in a register; the next segment is taken while it waits.
// A stalled result holds, and the block holds its next result until the slot frees.
`default_nettype none

module tcp_receive_reassembly_tracker
   import tcp_rrt_pkg::*;
#(
   parameter int MAP_BYTES = 16384
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire req_payload_type         req_payload,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      rsp_payload_type         rsp_payload,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [CSR_DATA_W-1:0]   csr_prdata,
   output      logic                    csr_pready
);

   localparam int OFF_W = $clog2(MAP_BYTES + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_WIN,
      S_MAP,
      S_DONE
   } seg_state_type;

   seg_state_type     state_ff;
   req_payload_type   seg_ff;
   logic [31:0]       off_ff;
   logic              send_ack_ff;
   logic              len_err_ff;
   logic              in_window_ff;
   logic              below_max_ff;
   logic [1:0]        fin_status_ff;
   logic [31:0]       highest_ff;
   logic [31:0]       count_ff;
   logic [15:0]       longest_ff;
   logic [31:0]       initial_seq_ff;
   logic [15:0]       window_size_ff;
   logic [15:0]       max_segment_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff;

   map_ctl_type       map_ctl;
   map_sts_type       map_sts;
   logic [OFF_W-1:0]  next_exp;
   logic [OFF_W-1:0]  map_lo;
   logic [OFF_W-1:0]  map_hi;

   logic              csr_write;
   logic              req_take;
   logic              rsp_free;
   logic              len_err;
   logic              has_data;
   logic [31:0]       seg_end;
   logic [31:0]       count_next;
   logic [31:0]       rel_off;
   logic              win_hit;
   logic [32:0]       end_off;
   logic              lo_in_map;

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_INITIAL_SEQ: csr_prdata = initial_seq_ff;
         REG_WINDOW_SIZE: csr_prdata = {16'd0, window_size_ff};
         REG_MAX_SEGMENT: csr_prdata = {16'd0, max_segment_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Segment checks
   assign len_err    = seg_ff.data_length > max_segment_ff;
   assign has_data   = seg_ff.data_length != 16'd0;
   assign seg_end    = seg_ff.seq_number + {16'd0, seg_ff.data_length} - 32'd1;
   assign count_next = (has_data && count_ff != '1) ? count_ff + 32'd1 : count_ff;

   // Window test against the current next expected offset
   assign rel_off = off_ff - 32'(next_exp);
   assign win_hit = (rel_off < {16'd0, window_size_ff}) &&
                    ({1'b0, rel_off[15:0]} + {1'b0, seg_ff.data_length} <= {1'b0, window_size_ff});

   // Clip the marked range to the bitmap
   assign end_off   = {1'b0, off_ff} + {17'd0, seg_ff.data_length};
   assign lo_in_map = off_ff < 32'(MAP_BYTES);
   assign map_lo    = off_ff[OFF_W-1:0];
   assign map_hi    = (end_off >= 33'(MAP_BYTES)) ? OFF_W'(MAP_BYTES) : end_off[OFF_W-1:0];

   assign map_ctl.start = (state_ff == S_WIN) && win_hit;
   assign map_ctl.mark  = lo_in_map && has_data;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = !((state_ff == S_IDLE) && map_sts.ready);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         highest_ff     <= '0;
         count_ff       <= '0;
         longest_ff     <= '0;
         initial_seq_ff <= INITIAL_SEQ_RESET;
         window_size_ff <= WINDOW_SIZE_RESET;
         max_segment_ff <= MAX_SEGMENT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_paddr[3:2])
               REG_INITIAL_SEQ: initial_seq_ff <= csr_pwdata;
               REG_WINDOW_SIZE: window_size_ff <= csr_pwdata[15:0];
               REG_MAX_SEGMENT: max_segment_ff <= csr_pwdata[15:0];
               default: begin
               end
            endcase
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  seg_ff   <= req_payload;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               off_ff       <= seg_ff.seq_number - initial_seq_ff;
               in_window_ff <= 1'b0;
               if (len_err) begin
                  // oversized: flag and leave all state alone
                  send_ack_ff   <= 1'b0;
                  len_err_ff    <= 1'b1;
                  below_max_ff  <= 1'b0;
                  fin_status_ff <= FIN_NONE;
                  state_ff      <= S_DONE;
               end else begin
                  send_ack_ff  <= has_data;
                  len_err_ff   <= 1'b0;
                  count_ff     <= count_next;
                  if (seg_ff.data_length > longest_ff) begin
                     longest_ff <= seg_ff.data_length;
                  end
                  if (highest_ff < seg_end) begin
                     highest_ff   <= seg_end;
                     below_max_ff <= 1'b0;
                  end else begin
                     below_max_ff <= has_data;
                  end
                  if (!seg_ff.fin_flag) begin
                     fin_status_ff <= FIN_NONE;
                  end else if (count_next == '0) begin
                     fin_status_ff <= FIN_NO_DATA;
                  end else begin
                     fin_status_ff <= FIN_WITH_DATA;
                  end
                  state_ff <= S_WIN;
               end
            end
            S_WIN: begin
               in_window_ff <= win_hit;
               state_ff     <= win_hit ? S_MAP : S_DONE;
            end
            S_MAP: begin
               if (map_sts.done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff                  <= 1'b1;
                  rsp_payload_ff.ack_offset     <= 32'(next_exp);
                  rsp_payload_ff.send_ack       <= send_ack_ff;
                  rsp_payload_ff.length_error   <= len_err_ff;
                  rsp_payload_ff.in_window      <= in_window_ff;
                  rsp_payload_ff.below_max      <= below_max_ff;
                  rsp_payload_ff.data_segments  <= count_ff;
                  rsp_payload_ff.largest_length <= longest_ff;
                  rsp_payload_ff.finish_status  <= fin_status_ff;
                  state_ff                      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   tcp_rrt_map #(
      .MAP_BYTES (MAP_BYTES)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .ctl      (map_ctl),
      .lo       (map_lo),
      .hi       (map_hi),
      .sts      (map_sts),
      .next_exp (next_exp)
   );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the TCP receive reassembly tracker, with directed and random segments.

module tb_top
   import tcp_rrt_pkg::*;
;

   localparam int MAP_BYTES   = 16384;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 60;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit quiet        = 1'b0;  // no idling on either side
   bit hold_request = 1'b0;  // receiver starts one long hold-off
   int cycle_count;

   tcp_receive_reassembly_tracker #(.MAP_BYTES(MAP_BYTES)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   class reassembly_scoreboard;
      bit              byte_seen [MAP_BYTES];
      logic [31:0]     next_exp;
      logic [31:0]     highest;
      logic [31:0]     seg_count;
      logic [31:0]     initial_seq;
      logic [15:0]     longest;
      logic [15:0]     window;
      logic [15:0]     max_seg;
      rsp_payload_type ack_q [$];
      int              errors;

      function new();
         next_exp    = 32'd1;
         highest     = '0;
         seg_count   = '0;
         longest     = '0;
         initial_seq = INITIAL_SEQ_RESET;
         window      = WINDOW_SIZE_RESET;
         max_seg     = MAX_SEGMENT_RESET;
         errors      = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_INITIAL_SEQ: initial_seq = value;
            REG_WINDOW_SIZE: window = value[15:0];
            REG_MAX_SEGMENT: max_seg = value[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return ack_q.size();
      endfunction

      // Work out the acknowledgment that one accepted segment produces.
      function void note_segment(req_payload_type seg);
         rsp_payload_type ack;
         logic [31:0]     off;
         logic [31:0]     seg_end;
         logic [31:0]     rel_off;
         logic [63:0]     pos;
         logic [63:0]     stop;
         ack = '0;
         ack.finish_status = FIN_NONE;
         if (seg.data_length > max_seg) begin
            ack.length_error = 1'b1;
         end else begin
            off     = seg.seq_number - initial_seq;
            seg_end = seg.seq_number + {16'd0, seg.data_length} - 32'd1;
            rel_off = off - next_exp;
            if (seg.data_length > longest) longest = seg.data_length;
            if (seg.data_length != 16'd0) begin
               ack.send_ack = 1'b1;
               if (seg_count != 32'hFFFF_FFFF) seg_count = seg_count + 32'd1;
            end
            if (highest < seg_end) highest = seg_end;
            else if (seg.data_length != 16'd0) ack.below_max = 1'b1;
            if (rel_off < {16'd0, window} &&
                {32'd0, rel_off} + {48'd0, seg.data_length} <= {48'd0, window}) begin
               ack.in_window = 1'b1;
               // drop marks that fall past the end of the bitmap
               stop = {32'd0, off} + {48'd0, seg.data_length};
               if (stop > 64'(MAP_BYTES)) stop = 64'(MAP_BYTES);
               for (pos = {32'd0, off}; pos < stop; pos++) byte_seen[pos] = 1'b1;
               while (next_exp < 32'(MAP_BYTES) && byte_seen[next_exp]) next_exp = next_exp + 32'd1;
            end
            if (seg.fin_flag) ack.finish_status = (seg_count == 32'd0) ? FIN_NO_DATA : FIN_WITH_DATA;
         end
         ack.ack_offset     = next_exp;
         ack.data_segments  = seg_count;
         ack.largest_length = longest;
         ack_q.push_back(ack);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (ack_q.size() == 0) begin
            report("unexpected transaction, ack_offset", got.ack_offset, '0);
         end else begin
            want = ack_q.pop_front();
            if (got.ack_offset !== want.ack_offset)
               report("ack_offset", got.ack_offset, want.ack_offset);
            if (got.send_ack !== want.send_ack)
               report("send_ack", 32'(got.send_ack), 32'(want.send_ack));
            if (got.length_error !== want.length_error)
               report("length_error", 32'(got.length_error), 32'(want.length_error));
            if (got.in_window !== want.in_window)
               report("in_window", 32'(got.in_window), 32'(want.in_window));
            if (got.below_max !== want.below_max)
               report("below_max", 32'(got.below_max), 32'(want.below_max));
            if (got.data_segments !== want.data_segments)
               report("data_segments", got.data_segments, want.data_segments);
            if (got.largest_length !== want.largest_length)
               report("largest_length", 32'(got.largest_length), 32'(want.largest_length));
            if (got.finish_status !== want.finish_status)
               report("finish_status", 32'(got.finish_status), 32'(want.finish_status));
         end
      endtask
   endclass

   reassembly_scoreboard sb = new();

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet) return 0;
      if (roll < 70) return $urandom_range(0, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_length(logic [15:0] cap);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 16'd0;
      if (roll < 65) return 16'($urandom_range(1, (cap < 16'd48) ? 32'(cap) : 48));
      if (roll < 90) return 16'($urandom_range(1, (cap < 16'd400) ? 32'(cap) : 400));
      return 16'($urandom_range(1, 32'(cap)));
   endfunction

   // Mostly well-formed traffic around the next expected byte, the rest noise.
   function automatic req_payload_type pick_segment();
      req_payload_type seg;
      logic [31:0]     base;
      int              roll;
      base = sb.initial_seq + sb.next_exp;
      roll = $urandom_range(0, 99);
      seg.fin_flag    = ($urandom_range(0, 7) == 0);
      seg.data_length = pick_length(sb.max_seg);
      if (roll < 45) begin
         seg.seq_number = base;
      end else if (roll < 63) begin
         seg.seq_number = base + $urandom_range(1, 2500);
      end else if (roll < 75) begin
         seg.seq_number = base - $urandom_range(1, 3000);
      end else if (roll < 85) begin
         seg.seq_number  = base;
         seg.data_length = (sb.max_seg == 16'hFFFF) ? 16'hFFFF :
                           16'($urandom_range(32'(sb.max_seg) + 1, 65535));
      end else begin
         seg.seq_number  = $urandom();
         seg.data_length = 16'($urandom());
      end
      return seg;
   endfunction

   task automatic send_segment(input req_payload_type seg);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= seg;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_segment(seg);
   endtask

   task automatic send_fields(input logic [31:0] seq, input logic [15:0] len, input logic fin);
      req_payload_type seg;
      seg.seq_number  = seq;
      seg.data_length = len;
      seg.fin_flag    = fin;
      send_segment(seg);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_directed();
      send_fields(32'd5, 16'd0, 1'b1);             // FIN before any data
      send_fields(32'd1, 16'd1461, 1'b0);          // one byte over the limit
      send_fields(32'd1, 16'hFFFF, 1'b1);          // largest length, oversized FIN
      send_fields(32'd1, 16'd1460, 1'b0);          // full-size, in order
      send_fields(32'd1, 16'd100, 1'b0);           // retransmission behind the window
      send_fields(32'd3000, 16'd200, 1'b0);        // leaves a hole
      send_fields(32'd1461, 16'd1539, 1'b1);       // fills the hole, scan walks past it
      send_fields(32'd0, 16'd0, 1'b0);             // empty segment ends at all ones
      send_fields(32'hFFFF_FFFF, 16'd1, 1'b1);     // ends equal to highest seen
      send_fields(32'hFFFF_FFFF, 16'd2, 1'b0);     // end wraps to zero
      send_fields(32'd68734, 16'd1, 1'b0);         // last byte of the window, past the map
      send_fields(32'd68735, 16'd0, 1'b0);         // just outside the window
      send_fields(32'd16380, 16'd100, 1'b0);       // straddles the end of the map
      send_fields(32'd3200, 16'd1, 1'b1);          // FIN with data
      send_fields(32'd3201, 16'd0, 1'b0);
      send_fields(32'd3201, 16'd48, 1'b0);
      req_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [31:0] init, input logic [31:0] win,
                            input logic [31:0] maxseg, input int count,
                            input bit calm, input bit with_hold);
      req_payload_type seg;
      settle();
      write_reg(REG_INITIAL_SEQ, init);
      write_reg(REG_WINDOW_SIZE, win);
      write_reg(REG_MAX_SEGMENT, maxseg);
      quiet = calm;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) hold_request = 1'b1;
         seg = pick_segment();
         // now and then a maximum-length segment at the next expected byte
         if (sb.max_seg == 16'hFFFF && i % 50 == 7) begin
            seg.seq_number  = sb.initial_seq + sb.next_exp;
            seg.data_length = 16'hFFFF;
         end
         send_segment(seg);
      end
      req_valid <= 1'b0;
   endtask

   // Receiver: random stalls, one long hold-off on request.
   initial begin : receiver
      int stall_left;
      int free_left;
      int hold_left;
      stall_left = 0;
      free_left  = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            free_left  = $urandom_range(0, 12);
            stall_left = idle_len();
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) sb.check_result(rsp_payload);
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase($urandom(), 32'd65535, 32'd1460, 250, 1'b0, 1'b1);
      run_phase(32'hFFFF_FFFF, 32'd0, 32'd65535, 60, 1'b0, 1'b0);
      run_phase(32'd0, 32'd1, 32'd1, 100, 1'b1, 1'b0);
      run_phase($urandom(), $urandom_range(200, 4000), $urandom_range(1, 1460), 200, 1'b0, 1'b0);
      run_phase($urandom(), 32'd65535, 32'd65535, 220, 1'b0, 1'b0);
      settle();
      repeat (60) @(posedge clock);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/tcp_rrt_pkg.sv
design/tcp_rrt_ram.sv
design/tcp_rrt_map.sv
design/tcp_receive_reassembly_tracker.sv
test/tb_top.sv
